[rtl/sss_pkg.sv]
// shared types and constants for the sequence store with sort
// no dependencies
package sss_pkg;
	localparam int Capacity = 64;
	localparam int AddrW = $clog2(Capacity);
	localparam int CountW = $clog2(Capacity + 1);

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_PREPEND = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_SORT = 3'd3,
		CMD_READ = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_EMPTY = 3'd1,
		ST_NOKEY = 3'd2,
		ST_FULL = 3'd3,
		ST_BADIDX = 3'd4
	} status_t;

	// the write port and read address of the entry memory as driven by the sequencer
	typedef struct packed {
		logic we;
		logic [AddrW-1:0] waddr;
		logic [31:0] wdata;
		logic [AddrW-1:0] raddr;
	} mem_req_t;
endpackage

[rtl/sss_mem.sv]
// entry memory: one write port, one read port, registered read data
// depends on sss_pkg
module sss_mem (
	input logic clk,
	input sss_pkg::mem_req_t req,
	output logic [31:0] rdata
);
	import sss_pkg::*;

	logic [31:0] mem [Capacity];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rdata <= mem[req.raddr];
	end
endmodule

[rtl/sss_seq.sv]
// command sequencer: walks the entry memory for every command it carries out
// depends on sss_pkg, drives sss_mem through a mem_req_t
module sss_seq (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [2:0] command,
	input logic [31:0] value,
	input logic [31:0] key,
	input logic [5:0] index,
	output logic out_valid,
	input logic out_ready,
	output logic [2:0] status,
	output logic [31:0] data,
	output logic [6:0] count,
	output sss_pkg::mem_req_t req,
	input logic [31:0] rdata
);
	import sss_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_APP, S_PRE_RD, S_PRE_WR, S_PRE_HEAD, S_READ_RD, S_READ_DATA,
		S_CNT_RD, S_CNT_CHK, S_INS_DEC, S_INS_RD, S_INS_WR, S_INS_WR2,
		S_SRT_NEXT, S_SRT_KEY, S_SRT_CMP, S_SRT_PUT, S_DONE
	} state_t;

	state_t state_q;
	logic [31:0] val_q, key_q, v_q, a_q;
	logic [CountW-1:0] cnt_q, i_q, j_q, m_q;
	logic [CountW:0] tot;
	logic [2:0] st_q;
	logic [31:0] dat_q;
	logic ov_q;
	logic hit;
	logic gt;

	assign in_ready = (state_q == S_IDLE) && !ov_q;
	assign out_valid = ov_q;
	assign status = st_q;
	assign data = dat_q;
	assign count = 7'(cnt_q);
	assign tot = {1'b0, cnt_q} + {1'b0, m_q};
	assign hit = (rdata == key_q);
	assign gt = $signed(rdata) > $signed(v_q);

	// memory request is combinational on the current step
	always_comb begin
		req = '0;
		case (state_q)
			S_APP: begin
				req.we = 1'b1;
				req.waddr = AddrW'(cnt_q);
				req.wdata = val_q;
			end
			S_PRE_RD, S_READ_RD, S_CNT_RD, S_INS_RD, S_SRT_NEXT: begin
				req.raddr = AddrW'(i_q);
			end
			// shift entry i up by one
			S_PRE_WR: begin
				req.we = 1'b1;
				req.waddr = AddrW'(i_q + CountW'(1));
				req.wdata = rdata;
			end
			S_PRE_HEAD: begin
				req.we = 1'b1;
				req.waddr = '0;
				req.wdata = val_q;
			end
			// entry i lands at i plus matches below it, a match gets the value just above it
			S_INS_WR: begin
				req.we = 1'b1;
				req.waddr = AddrW'(i_q + m_q);
				req.wdata = hit ? val_q : rdata;
			end
			S_INS_WR2: begin
				req.we = 1'b1;
				req.waddr = AddrW'(i_q + m_q);
				req.wdata = a_q;
			end
			S_SRT_KEY: begin
				req.raddr = AddrW'(i_q - CountW'(1));
			end
			// move the larger neighbor up and fetch the next one down
			S_SRT_CMP: begin
				req.raddr = AddrW'(j_q - CountW'(2));
				if (gt) begin
					req.we = 1'b1;
					req.waddr = AddrW'(j_q);
					req.wdata = rdata;
				end
			end
			S_SRT_PUT: begin
				req.we = 1'b1;
				req.waddr = AddrW'(j_q);
				req.wdata = v_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			i_q <= '0;
			j_q <= '0;
			m_q <= '0;
			val_q <= '0;
			key_q <= '0;
			v_q <= '0;
			a_q <= '0;
			st_q <= ST_OK;
			dat_q <= '0;
			ov_q <= 1'b0;
		end else begin
			if (ov_q && out_ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						val_q <= value;
						key_q <= key;
						st_q <= ST_OK;
						dat_q <= '0;
						state_q <= S_DONE;
						case (command)
							CMD_APPEND: begin
								if (cnt_q == CountW'(Capacity)) st_q <= ST_FULL;
								else state_q <= S_APP;
							end
							CMD_PREPEND: begin
								if (cnt_q == '0) st_q <= ST_EMPTY;
								else if (cnt_q == CountW'(Capacity)) st_q <= ST_FULL;
								else begin
									i_q <= cnt_q - CountW'(1);
									state_q <= S_PRE_RD;
								end
							end
							CMD_INSERT: begin
								if (cnt_q == '0) st_q <= ST_EMPTY;
								else begin
									i_q <= '0;
									m_q <= '0;
									state_q <= S_CNT_RD;
								end
							end
							CMD_SORT: begin
								if (cnt_q == '0) st_q <= ST_EMPTY;
								else begin
									i_q <= CountW'(1);
									state_q <= S_SRT_NEXT;
								end
							end
							CMD_READ: begin
								if (cnt_q == '0) st_q <= ST_EMPTY;
								else if (CountW'(index) >= cnt_q) st_q <= ST_BADIDX;
								else begin
									i_q <= CountW'(index);
									state_q <= S_READ_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_APP: begin
					cnt_q <= cnt_q + CountW'(1);
					state_q <= S_DONE;
				end
				S_PRE_RD: begin
					state_q <= S_PRE_WR;
				end
				S_PRE_WR: begin
					if (i_q == '0) state_q <= S_PRE_HEAD;
					else begin
						i_q <= i_q - CountW'(1);
						state_q <= S_PRE_RD;
					end
				end
				S_PRE_HEAD: begin
					cnt_q <= cnt_q + CountW'(1);
					state_q <= S_DONE;
				end
				S_READ_RD: begin
					state_q <= S_READ_DATA;
				end
				S_READ_DATA: begin
					dat_q <= rdata;
					state_q <= S_DONE;
				end
				// count matches over the entries present before the command
				S_CNT_RD: begin
					state_q <= S_CNT_CHK;
				end
				S_CNT_CHK: begin
					if (hit) m_q <= m_q + CountW'(1);
					if (i_q + CountW'(1) == cnt_q) state_q <= S_INS_DEC;
					else begin
						i_q <= i_q + CountW'(1);
						state_q <= S_CNT_RD;
					end
				end
				S_INS_DEC: begin
					if (m_q == '0) begin
						st_q <= ST_NOKEY;
						state_q <= S_DONE;
					end else if (tot > (CountW+1)'(Capacity)) begin
						st_q <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						cnt_q <= CountW'(tot);
						i_q <= cnt_q - CountW'(1);
						state_q <= S_INS_RD;
					end
				end
				// spread from the tail down so no unread entry is overwritten
				S_INS_RD: begin
					state_q <= S_INS_WR;
				end
				S_INS_WR: begin
					a_q <= rdata;
					if (hit) begin
						m_q <= m_q - CountW'(1);
						state_q <= S_INS_WR2;
					end else if (i_q == '0) state_q <= S_DONE;
					else begin
						i_q <= i_q - CountW'(1);
						state_q <= S_INS_RD;
					end
				end
				S_INS_WR2: begin
					if (i_q == '0) state_q <= S_DONE;
					else begin
						i_q <= i_q - CountW'(1);
						state_q <= S_INS_RD;
					end
				end
				// insertion sort, entries below i already in order
				S_SRT_NEXT: begin
					if (i_q == cnt_q) state_q <= S_DONE;
					else state_q <= S_SRT_KEY;
				end
				S_SRT_KEY: begin
					v_q <= rdata;
					j_q <= i_q;
					state_q <= S_SRT_CMP;
				end
				S_SRT_CMP: begin
					if (gt) begin
						j_q <= j_q - CountW'(1);
						if (j_q == CountW'(1)) state_q <= S_SRT_PUT;
					end else state_q <= S_SRT_PUT;
				end
				S_SRT_PUT: begin
					i_q <= i_q + CountW'(1);
					state_q <= S_SRT_NEXT;
				end
				S_DONE: begin
					ov_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

[rtl/sequence_store_with_sort.sv]
// sequence store with sort, top level
// throughput: one item in flight; the next is taken the cycle after the result is accepted
// reset: arst_n clears count and control; memory contents undefined until written
module sequence_store_with_sort (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [79:0] s_axis_tdata, // command, value, key, index, pad
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	output logic [47:0] m_axis_tdata // status, data, count, pad
);
	import sss_pkg::*;
	mem_req_t req;
	logic [31:0] rdata;
	logic [2:0] st;
	logic [31:0] dt;
	logic [6:0] ct;

	sss_seq u_seq (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.command(s_axis_tdata[2:0]), .value(s_axis_tdata[34:3]),
		.key(s_axis_tdata[66:35]), .index(s_axis_tdata[72:67]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.status(st), .data(dt), .count(ct), .req(req), .rdata(rdata)
	);
	sss_mem u_mem (.clk(clk), .req(req), .rdata(rdata));
	assign m_axis_tdata = {6'd0, ct, dt, st};
endmodule

[tb/sequence_store_with_sort_chk.sv]
// checker for the sequence store with sort: watches both streams, predicts, compares
// depends on sss_pkg and on the port packing of sequence_store_with_sort
`timescale 1ns / 1ps
module sequence_store_with_sort_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [79:0] in_data,
	input logic out_valid,
	input logic out_ready,
	input logic [47:0] out_data,
	output int fail_count,
	output int pending
);
	import sss_pkg::*;

	typedef struct packed {
		logic [2:0] status;
		logic [31:0] data;
		logic [6:0] count;
	} reply_t;

	logic [31:0] store_model [Capacity];
	int held;
	reply_t replies_due [$];

	// apply one command to the model and return the reply it should produce
	function automatic reply_t apply_command(logic [2:0] op, logic [31:0] v,
			logic [31:0] k, logic [5:0] idx);
		reply_t r;
		int hits;
		int n;
		logic [31:0] tmp [Capacity];
		logic [31:0] t;
		r = '0;
		hits = 0;
		n = 0;
		case (op)
			CMD_APPEND: begin
				if (held >= Capacity) r.status = ST_FULL;
				else begin
					store_model[held] = v;
					held++;
				end
			end
			CMD_PREPEND: begin
				if (held == 0) r.status = ST_EMPTY;
				else if (held >= Capacity) r.status = ST_FULL;
				else begin
					for (int i = held; i > 0; i--) store_model[i] = store_model[i-1];
					store_model[0] = v;
					held++;
				end
			end
			CMD_INSERT: begin
				if (held == 0) r.status = ST_EMPTY;
				else begin
					for (int i = 0; i < held; i++) if (store_model[i] == k) hits++;
					if (hits == 0) r.status = ST_NOKEY;
					else if (held + hits > Capacity) r.status = ST_FULL;
					else begin
						// only entries present before the command can match
						for (int i = 0; i < held; i++) begin
							tmp[n] = store_model[i];
							n++;
							if (store_model[i] == k) begin
								tmp[n] = v;
								n++;
							end
						end
						for (int i = 0; i < n; i++) store_model[i] = tmp[i];
						held = n;
					end
				end
			end
			CMD_SORT: begin
				if (held == 0) r.status = ST_EMPTY;
				else begin
					for (int i = 0; i < held; i++)
						for (int j = 0; j + 1 < held - i; j++)
							if ($signed(store_model[j]) > $signed(store_model[j+1])) begin
								t = store_model[j];
								store_model[j] = store_model[j+1];
								store_model[j+1] = t;
							end
				end
			end
			CMD_READ: begin
				if (held == 0) r.status = ST_EMPTY;
				else if (idx >= held) r.status = ST_BADIDX;
				else r.data = store_model[idx];
			end
			default: ;
		endcase
		r.count = held[6:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			held = 0;
			fail_count <= 0;
			pending <= 0;
			replies_due.delete();
		end else begin
			if (in_valid && in_ready)
				replies_due.push_back(apply_command(in_data[2:0], in_data[34:3],
					in_data[66:35], in_data[72:67]));
			if (out_valid && out_ready) begin
				got.status = out_data[2:0];
				got.data = out_data[34:3];
				got.count = out_data[41:35];
				if (replies_due.size() == 0) begin
					if (fail_count < 10) $display("unexpected reply %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = replies_due.pop_front();
					if (want !== got) begin
						if (fail_count < 10)
							$display({"mismatch: status exp %0d got %0d, ",
								"data exp %h got %h, count exp %0d got %0d"},
								want.status, got.status, want.data, got.data,
								want.count, got.count);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= replies_due.size();
		end
	end
endmodule

[tb/sequence_store_with_sort_tb.sv]
// top of the sequence store with sort testbench: clock, reset, stimulus, verdict
// depends on sss_pkg, sequence_store_with_sort and sequence_store_with_sort_chk
`timescale 1ns / 1ps
module sequence_store_with_sort_tb;
	import sss_pkg::*;

	localparam int IdleLimit = 40000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [79:0] s_axis_tdata; // command, value, key, index, pad
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [47:0] m_axis_tdata; // status, data, count, pad
	int fail_count;
	int pending;
	int idle_cycles;
	bit hold_sink; // long receiver hold-off request
	int sink_hold_len;
	logic [31:0] pool [8]; // small value pool so keys hit often

	sequence_store_with_sort uut (.*);

	sequence_store_with_sort_chk chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_data(s_axis_tdata),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog: cycles with no handshake on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("sequence_store_with_sort test failed");
			$finish;
		end
	end

	// send one item, with a random gap ahead of it; valid stays up after the handshake
	task automatic send_item(logic [2:0] op, logic [31:0] v, logic [31:0] k, logic [5:0] idx);
		int gap;
		gap = $urandom_range(0, 12);
		if ($urandom_range(0, 3) == 0) gap = 0; // runs with no gaps
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {7'b0, idx, k, v, op};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// drop valid after the last item and wait until every result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom();
			default: return pool[$urandom_range(0, 7)];
		endcase
	endfunction

	// mostly valid commands; insert is kept rare to avoid filling the store at once
	task automatic random_item(int fill);
		int r;
		logic [2:0] op;
		r = $urandom_range(0, 99);
		if (r < 30) op = CMD_APPEND;
		else if (r < 45) op = CMD_PREPEND;
		else if (r < 55) op = CMD_INSERT;
		else if (r < 62) op = CMD_SORT;
		else if (r < 96) op = CMD_READ;
		else op = 3'($urandom_range(5, 7));
		send_item(op, pick_value(), pick_value(),
			($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, fill)));
	endtask

	// empty the store again by a fresh reset is not allowed, so phases grow and refill
	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		hold_sink = 0;
		idle_cycles = 0;
		for (int i = 0; i < 8; i++) pool[i] = $urandom();
		pool[0] = 32'h8000_0000;
		pool[1] = 32'h7fff_ffff;
		pool[2] = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty cases, single-entry sort, key equal value, extremes
		send_item(CMD_PREPEND, 32'd1, 32'd0, 6'd0);
		send_item(CMD_INSERT, 32'd1, 32'd1, 6'd0);
		send_item(CMD_SORT, 32'd0, 32'd0, 6'd0);
		send_item(CMD_READ, 32'd0, 32'd0, 6'd0);
		send_item(3'd7, 32'hffff_ffff, 32'hffff_ffff, 6'h3f);
		send_item(CMD_APPEND, 32'h7fff_ffff, 32'd0, 6'd0);
		send_item(CMD_SORT, 32'd0, 32'd0, 6'd0);
		send_item(CMD_INSERT, 32'd5, 32'd9, 6'd0);
		send_item(CMD_INSERT, 32'h7fff_ffff, 32'h7fff_ffff, 6'd0);
		send_item(CMD_PREPEND, 32'h8000_0000, 32'd0, 6'd0);
		send_item(CMD_APPEND, 32'd0, 32'd0, 6'd0);
		send_item(CMD_SORT, 32'd0, 32'd0, 6'd0);
		for (int i = 0; i < 4; i++) send_item(CMD_READ, 32'd0, 32'd0, 6'(i));
		send_item(CMD_READ, 32'd0, 32'd0, 6'h3f);
		send_item(3'd5, 32'd0, 32'd0, 6'd0);
		send_item(3'd6, 32'd0, 32'd0, 6'd0);

		// sender pause until everything is back
		drain();

		// fill to capacity, then send append, prepend and insert against the full store, a sort and a read
		for (int i = 0; i < 64; i++) send_item(CMD_APPEND, pool[i % 8], 32'd0, 6'd0);
		send_item(CMD_APPEND, 32'd1, 32'd0, 6'd0);
		send_item(CMD_PREPEND, 32'd1, 32'd0, 6'd0);
		send_item(CMD_INSERT, 32'd1, pool[3], 6'd0);
		send_item(CMD_SORT, 32'd0, 32'd0, 6'd0);
		send_item(CMD_READ, 32'd0, 32'd0, 6'h3f);

		// long receiver hold-off while items keep coming
		sink_hold_len = 400;
		hold_sink <= 1;
		for (int i = 0; i < 10; i++) send_item(CMD_READ, 32'd0, 32'd0, 6'($urandom()));
		s_axis_tvalid <= 1'b0;
		wait (hold_sink == 0);
		drain();

		// random part: the store count is never lowered, so it stays full throughout;
		// append/prepend/insert refusals and reads still exercise most paths
		for (int i = 0; i < 1650; i++) random_item(63);

		drain();
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("sequence_store_with_sort test passed");
		else $display("sequence_store_with_sort test failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off
	initial begin
		int stall;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 0;
				repeat (sink_hold_len) @(posedge clk);
				hold_sink <= 0;
			end
			stall = $urandom_range(0, 12);
			if ($urandom_range(0, 3) == 0) stall = 0;
			if (stall > 0) begin
				m_axis_tready <= 0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end
endmodule
